FILE: rtl/core/bdbp_pkg.sv
package bdbp_pkg;

  localparam int unsigned MAX_AGGREGATE   = 4096;
  localparam int unsigned MAX_DESCRIPTORS = 65536;
  localparam int unsigned AGGREGATE_RESET = 512;

  localparam logic KIND_HEADER     = 1'b0;
  localparam logic KIND_DESCRIPTOR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [16:0] descriptor_count;
    logic [63:0] total_bytes;
    logic [63:0] descriptor_size;
  } bdbp_in_t;

  typedef struct packed {
    logic [15:0] task_number;
    logic [15:0] first_descriptor;
    logic [12:0] batch_count;
    logic [63:0] batch_bytes;
    logic        last_task;
  } bdbp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLOSE,
    ST_TDIV,
    ST_MUL,
    ST_BOUND,
    ST_BDIV
  } bdbp_state_t;

  typedef struct packed {
    logic hdr_load;
    logic desc_add;
    logic close_task;
    logic div_start;
    logic div_sel_bytes;
    logic tasks_load;
    logic mul_load;
    logic bound_load;
    logic target_load;
  } bdbp_cmd_t;

  typedef struct packed {
    logic batch_active;
    logic item_is_desc;
    logic hdr_nonzero;
    logic close_hit;
    logic last_hit;
    logic out_valid;
  } bdbp_sts_t;

endpackage

FILE: rtl/core/bdbp_div.sv
module bdbp_div import bdbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic        rem_nz
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] quo_r;
  logic [16:0] rem_r;
  logic [16:0] dvs_r;
  logic [17:0] trial;
  logic        fits;
  logic [16:0] rem_nxt;

  // One restoring step per cycle: shift in the next dividend bit.
  always_comb begin
    trial   = {rem_r, quo_r[63]};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? 17'(trial - {1'b0, dvs_r}) : trial[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[62:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = rem_r != '0;

endmodule

FILE: rtl/core/bdbp_ctrl.sv
module bdbp_ctrl import bdbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  input  bdbp_sts_t  sts,
  input  logic       div_done,
  output bdbp_cmd_t  cmd
);

  bdbp_state_t state_r;
  bdbp_state_t state_nxt;
  logic        accept;
  logic        out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // The result register takes a new beat once the waiting one leaves.
  assign out_free = !sts.out_valid || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!sts.item_is_desc && sts.hdr_nonzero) begin
            state_nxt = ST_TDIV;
          end else if (sts.item_is_desc && sts.batch_active) begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: state_nxt = sts.close_hit ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: begin
        if (out_free) begin
          state_nxt = sts.last_hit ? ST_IDLE : ST_MUL;
        end
      end
      ST_TDIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = ST_BDIV;
      ST_BDIV:  if (div_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !sts.item_is_desc && sts.hdr_nonzero) begin
          cmd.hdr_load  = 1'b1;
          cmd.div_start = 1'b1;
        end
        if (accept && sts.item_is_desc && sts.batch_active) begin
          cmd.desc_add = 1'b1;
        end
      end
      // Hold the close while a result beat still waits.
      ST_CLOSE: cmd.close_task = out_free;
      ST_TDIV:  cmd.tasks_load = div_done;
      ST_MUL:   cmd.mul_load = 1'b1;
      ST_BOUND: begin
        cmd.bound_load    = 1'b1;
        cmd.div_start     = 1'b1;
        cmd.div_sel_bytes = 1'b1;
      end
      ST_BDIV: begin
        cmd.div_sel_bytes = 1'b1;
        cmd.target_load   = div_done;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/bdbp_dp.sv
module bdbp_dp import bdbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bdbp_cmd_t   cmd,
  output bdbp_sts_t   sts,
  input  bdbp_in_t    in_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bdbp_out_t   out_data,
  output logic [63:0] div_dividend,
  output logic [16:0] div_divisor,
  input  logic [63:0] div_quotient,
  input  logic        div_rem_nz
);

  logic [12:0] agg_r;
  logic        batch_active_r;
  logic        out_valid_r;
  bdbp_out_t   out_r;
  logic [16:0] tasks_left_r;
  logic [16:0] desc_left_r;
  logic [63:0] bytes_left_r;
  logic [15:0] task_counter_r;
  logic [15:0] start_pos_r;
  logic [12:0] open_count_r;
  logic [63:0] open_bytes_r;
  logic [16:0] lower_r;
  logic [12:0] upper_r;
  logic [63:0] target_r;
  logic [29:0] cap_r;

  logic [12:0] agg_eff;
  logic [16:0] tl_eff;
  logic [16:0] n_eff;
  logic [64:0] bytes_sum;
  logic [16:0] desc_after;
  logic [16:0] tasks_dec;
  logic [16:0] room;

  always_comb begin
    if (agg_r == '0) begin
      agg_eff = 13'd1;
    end else if (agg_r > 13'(MAX_AGGREGATE)) begin
      agg_eff = 13'(MAX_AGGREGATE);
    end else begin
      agg_eff = agg_r;
    end
    tl_eff = (tasks_left_r == '0) ? 17'd1 : tasks_left_r;
    n_eff  = (in_data.descriptor_count > 17'(MAX_DESCRIPTORS)) ? 17'(MAX_DESCRIPTORS)
                                                             : in_data.descriptor_count;
    bytes_sum  = {1'b0, open_bytes_r} + {1'b0, in_data.descriptor_size};
    desc_after = (desc_left_r > {4'b0, open_count_r}) ? desc_left_r - {4'b0, open_count_r}
                                                     : 17'd0;
    tasks_dec  = (tasks_left_r != '0) ? tasks_left_r - 17'd1 : 17'd0;
    room       = (desc_left_r >= tl_eff) ? desc_left_r - tl_eff + 17'd1 : 17'd1;
  end

  assign div_dividend = cmd.div_sel_bytes ? bytes_left_r : {47'b0, n_eff - 17'd1};
  assign div_divisor  = cmd.div_sel_bytes ? tl_eff : {4'b0, agg_eff};

  always_comb begin
    sts.batch_active = batch_active_r;
    sts.item_is_desc = in_data.kind == KIND_DESCRIPTOR;
    sts.hdr_nonzero  = in_data.descriptor_count != '0;
    sts.close_hit    = (open_count_r >= upper_r) ||
                       (({4'b0, open_count_r} >= lower_r) && (open_bytes_r >= target_r));
    sts.last_hit     = desc_after == '0;
    sts.out_valid    = out_valid_r;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_r          <= 13'(AGGREGATE_RESET);
      batch_active_r <= 1'b0;
      out_valid_r    <= 1'b0;
      tasks_left_r   <= '0;
      desc_left_r    <= '0;
      bytes_left_r   <= '0;
      task_counter_r <= '0;
      start_pos_r    <= '0;
      open_count_r   <= '0;
      open_bytes_r   <= '0;
      lower_r        <= '0;
      upper_r        <= '0;
      target_r       <= '0;
      cap_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        agg_r <= cfg_data;
      end
      if (cmd.close_task) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.hdr_load) begin
        batch_active_r <= 1'b1;
        desc_left_r    <= n_eff;
        bytes_left_r   <= in_data.total_bytes;
        task_counter_r <= '0;
        start_pos_r    <= '0;
      end
      if (cmd.tasks_load) begin
        tasks_left_r <= div_quotient[16:0] + 17'd1;
      end
      if (cmd.mul_load) begin
        cap_r <= {13'b0, tl_eff - 17'd1} * {17'b0, agg_eff};
      end
      if (cmd.bound_load) begin
        lower_r <= ({13'b0, desc_left_r} > cap_r) ? desc_left_r - cap_r[16:0] : 17'd1;
        upper_r <= ({4'b0, agg_eff} < room) ? agg_eff : room[12:0];
      end
      if (cmd.target_load) begin
        target_r     <= div_quotient + {63'b0, div_rem_nz};
        open_count_r <= '0;
        open_bytes_r <= '0;
      end
      if (cmd.desc_add) begin
        open_count_r <= open_count_r + 13'd1;
        open_bytes_r <= bytes_sum[64] ? '1 : bytes_sum[63:0];
      end
      if (cmd.close_task) begin
        desc_left_r    <= desc_after;
        start_pos_r    <= start_pos_r + {3'b0, open_count_r};
        bytes_left_r   <= (bytes_left_r > open_bytes_r) ? bytes_left_r - open_bytes_r : '0;
        task_counter_r <= task_counter_r + 16'd1;
        // Hold at least one task while descriptors remain.
        tasks_left_r   <= (tasks_dec == '0) ? 17'd1 : tasks_dec;
        if (desc_after == '0) begin
          batch_active_r <= 1'b0;
          open_count_r   <= '0;
          open_bytes_r   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close_task) begin
      out_r.task_number      <= task_counter_r;
      out_r.first_descriptor <= start_pos_r;
      out_r.batch_count      <= open_count_r;
      out_r.batch_bytes      <= open_bytes_r;
      out_r.last_task        <= desc_after == '0;
    end
  end

endmodule

FILE: rtl/core/balanced_descriptor_batch_partitioner.sv
// Nonzero header beat: next beat taken after the 64-step task-count divide, the bound
// multiply and a 64-step byte-target divide. Descriptor beat that keeps the task open:
// added, then checked. One that closes it: the result is registered once the output is
// free, then, unless last, the bound multiply and byte-target divide on the shared
// one-bit-per-cycle divider run first. A stalled result delays the close.
// Reset (rst_n low, synchronous): no batch, output empty, aggregate limit 512.
module balanced_descriptor_batch_partitioner import bdbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bdbp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output bdbp_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  bdbp_cmd_t   cmd;
  bdbp_sts_t   sts;
  logic        div_done;
  logic [63:0] div_dividend;
  logic [16:0] div_divisor;
  logic [63:0] div_quotient;
  logic        div_rem_nz;

  bdbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  bdbp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quotient (div_quotient),
    .div_rem_nz   (div_rem_nz)
  );

  bdbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .rem_nz   (div_rem_nz)
  );

endmodule

FILE: rtl/core/bdbp_checker.sv
module bdbp_checker import bdbp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input bdbp_out_t   out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.batch_count != '0 &&
                  out_data.batch_count <= 13'(MAX_AGGREGATE))
    else $error("task count out of range");

  // A new result comes from the close step, where no input beat is taken.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a closing step");

endmodule

bind balanced_descriptor_batch_partitioner bdbp_checker u_bdbp_checker (.*);
